[rtl/core/mspt_pkg.sv]
// shared types and constants for the periodic timer core
package mspt_pkg;

    localparam int unsigned US_PER_MS = 1000;

    // input modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_EXPIRE  = 3'd0;
    localparam logic [2:0] KIND_STARTED = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_STOPPED = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // one slot entry as held in the slot memory
    typedef struct packed {
        logic        repeat_en;
        logic [63:0] deadline;
        logic [31:0] interval_us;
        logic [7:0]  code;
        logic [7:0]  arg;
    } slot_entry_t;

    // one result word
    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] slot;
        logic [7:0] code;
        logic [7:0] arg;
        logic       last;
    } result_t;

endpackage

[rtl/core/mspt_slot_mem.sv]
// slot memory: one write port, one registered read port
module mspt_slot_mem
    import mspt_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int AW = 3
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  slot_entry_t         wdata,
    input  logic [AW-1:0]       raddr,
    output slot_entry_t         rdata
);

    slot_entry_t mem [SLOTS];

    // synchronous write and read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/multi_slot_periodic_timer_core.sv]
// top level of the multi-slot periodic timer core
// Usage: input words arrive on s_axis (tuser: mode; tdata: elapsed_us, interval_ms,
// repeating, event_code, event_arg, slot_id). Each word gives zero or more
// result words on m_axis (tuser: kind; tdata: slot, out_code, out_arg; tlast
// marks the final result of an input word).
// A start or stop word gives its result in the cycle after it is accepted; the next
// word is accepted once that result is taken.
// A tick scans the slots through the slot memory: a read state and a compare
// state per slot, an output state for each due slot and, for a due repeating
// slot, a catch-up state that advances its deadline one period a cycle. One word
// is worked on at a time; s_axis_tready is low while it is and while a result waits.
// Reset clears the time counter and all active flags; slot memory contents
// are not cleared and are written before first use.
// When the receiver holds m_axis_tready low, the result stays registered and
// the scan waits once it has a further result to pass on; nothing is dropped.
module multi_slot_periodic_timer_core
    import mspt_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // mode
    input  logic [63:0] s_axis_tdata,  // elapsed_us, interval_ms, repeating,
                                       // event_code, event_arg, slot_id, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [2:0]  m_axis_tuser,  // kind
    output logic [23:0] m_axis_tdata,  // slot, out_code, out_arg, zero pad
    output logic        m_axis_tlast
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_CATCH = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  in_mode;
    logic [15:0] in_elapsed;
    logic [21:0] in_period;
    logic        in_repeat;
    logic [7:0]  in_code, in_arg;
    logic [5:0]  in_slot;

    assign in_mode    = s_axis_tuser;
    assign in_elapsed = s_axis_tdata[15:0];
    assign in_period  = s_axis_tdata[37:16];
    assign in_repeat  = s_axis_tdata[38];
    assign in_code    = s_axis_tdata[46:39];
    assign in_arg     = s_axis_tdata[54:47];
    assign in_slot    = s_axis_tdata[60:55];

    logic [63:0]    now_reg, now_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [AW-1:0]  idx_reg, idx_next;
    slot_entry_t    ent_reg, ent_next;
    logic           vld_reg, vld_next;
    result_t        res_reg, res_next;
    result_t        pend_reg, pend_next;
    logic           pend_vld_reg, pend_vld_next;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    slot_entry_t    wdata, rdata;

    mspt_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // first free slot
    logic           free_found;
    logic [AW-1:0]  free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    logic [AW-1:0] cur;
    logic [31:0]   start_period;
    logic [64:0]   next_sum;
    logic [63:0]   next_deadline;
    logic          catch_done;
    assign cur           = idx_reg;
    assign start_period  = 32'(in_period) * 32'(US_PER_MS);
    // carry out means the advanced deadline is past any current time
    assign next_sum      = {1'b0, ent_reg.deadline} + {33'd0, ent_reg.interval_us};
    assign next_deadline = next_sum[63:0];
    assign catch_done    = next_sum[64] || (next_deadline > now_reg);
    assign raddr         = cur;
    assign s_axis_tready = (state_reg == ST_IDLE) && !vld_reg;
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {2'b00, res_reg.arg, res_reg.code, res_reg.slot};
    assign m_axis_tlast  = res_reg.last;

    // control and datapath
    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        active_next   = active_reg;
        idx_next      = idx_reg;
        ent_next      = ent_reg;
        vld_next      = vld_reg;
        res_next      = res_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        we            = 1'b0;
        waddr         = cur;
        wdata         = ent_reg;

        if (vld_reg && m_axis_tready)
        begin
            vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    priority if (in_mode == MODE_TICK)
                    begin
                        now_next      = now_reg + 64'(in_elapsed);
                        idx_next      = '0;
                        pend_vld_next = 1'b0;
                        state_next    = ST_READ;
                    end
                    else if (in_mode == MODE_START)
                    begin
                        vld_next = 1'b1;
                        res_next = '{kind: KIND_FULL, slot: '0, code: '0, arg: '0,
                                     last: 1'b1};
                        if (free_found)
                        begin
                            we                = 1'b1;
                            waddr             = free_idx;
                            wdata.repeat_en   = in_repeat;
                            wdata.interval_us = start_period;
                            wdata.deadline    = now_reg + 64'(start_period);
                            wdata.code        = in_code;
                            wdata.arg         = in_arg;
                            active_next[free_idx] = 1'b1;
                            res_next.kind   = KIND_STARTED;
                            res_next.slot   = 6'(free_idx);
                        end
                    end
                    else if (in_mode == MODE_STOP)
                    begin
                        vld_next = 1'b1;
                        res_next = '{kind: KIND_IGNORED, slot: in_slot, code: '0,
                                     arg: '0, last: 1'b1};
                        if (32'(in_slot) < 32'(SLOTS))
                        begin
                            active_next[in_slot[AW-1:0]] = 1'b0;
                            res_next.kind = KIND_STOPPED;
                        end
                    end
                    else
                    begin
                        // unused mode: no result and no state change
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ent_next = rdata;
                if (active_reg[cur] && !(rdata.deadline > now_reg))
                begin
                    state_next = ST_OUT;
                end
                else if (idx_reg == AW'(SLOTS - 1))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                // hold earlier result until the output register frees
                if (!pend_vld_reg || !vld_next)
                begin
                    if (pend_vld_reg)
                    begin
                        vld_next = 1'b1;
                        res_next = pend_reg;
                    end
                    pend_vld_next = 1'b1;
                    pend_next = '{kind: KIND_EXPIRE, slot: 6'(cur), code: ent_reg.code,
                                  arg: ent_reg.arg, last: 1'b0};
                    if (ent_reg.repeat_en && ent_reg.interval_us != '0)
                    begin
                        state_next = ST_CATCH;
                    end
                    else
                    begin
                        active_next[cur] = 1'b0;
                        state_next = (idx_reg == AW'(SLOTS - 1)) ? ST_FLUSH : ST_READ;
                        idx_next   = (idx_reg == AW'(SLOTS - 1)) ? idx_reg
                                                                 : idx_reg + AW'(1);
                    end
                end
            end
            ST_CATCH:
            begin
                // advance one period a cycle until past the current time
                ent_next.deadline = next_deadline;
                if (catch_done)
                begin
                    we         = 1'b1;
                    wdata      = ent_reg;
                    wdata.deadline = next_deadline;
                    state_next = (idx_reg == AW'(SLOTS - 1)) ? ST_FLUSH : ST_READ;
                    idx_next   = (idx_reg == AW'(SLOTS - 1)) ? idx_reg : idx_reg + AW'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!vld_next)
                begin
                    vld_next      = 1'b1;
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            active_reg   <= '0;
            vld_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            active_reg   <= active_next;
            vld_reg      <= vld_next;
            pend_vld_reg <= pend_vld_next;
            idx_reg      <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

endmodule
